>>> rtl/lzwe_pkg.sv
// shared types and constants of the lzw byte encoder
package lzwe_pkg;

  localparam int unsigned ByteCodes = 256;
  localparam int unsigned MaxCodes  = 4096;
  localparam int unsigned CodeW     = 12;
  localparam int unsigned NextW     = 13;
  localparam int unsigned KeyW      = 20;
  localparam int unsigned EpochW    = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic [CodeW-1:0] out_code;
    logic             final_code;
  } res_t;

endpackage

>>> rtl/lzw_byte_encoder.sv
// top level of the lzw byte encoder
//
//  channel | direction | handshake      | words
//  input   | in        | push_i, full_o | data_byte_i, final_byte_i
//  result  | out       | pop_i, empty_o | out_code_o, final_code_o
//
// a byte passes the idle, read and compare states, and read and compare again
// per extra probe (a message's first byte idle only); a last byte also passes
// the flush state. a sweep of all 2*2^clog2(limit) entries (8192 at the default)
// clears the table after reset and every 255th message while no byte is taken.
// a byte waits for room for two words in the four-word result queue, behind a
// two-word input queue, so either side can stall on its own.
module lzw_byte_encoder #(
  parameter int unsigned DICT_ENTRIES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [11:0] out_code_o,
  output logic        final_code_o
);
  lzwe_pkg::item_t in_w, item;
  lzwe_pkg::res_t  res_w, res_head;
  logic item_empty, item_pop, res_room, res_push;
  logic in_room2, res_full;

  assign in_w = '{data_byte: data_byte_i, final_byte: final_byte_i};

  lzwe_fifo #(.W($bits(lzwe_pkg::item_t)), .DEPTH(2)) u_in_q (
    .clk_i, .rst_ni,
    .push_i  (push_i),
    .wdata_i (in_w),
    .pop_i   (item_pop),
    .rdata_o (item),
    .full_o  (full_o),
    .empty_o (item_empty),
    .room2_o (in_room2)
  );

  lzwe_engine #(.DICT_ENTRIES(DICT_ENTRIES)) u_engine (
    .clk_i, .rst_ni,
    .item_valid_i (!item_empty && (in_room2 || !in_room2)),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_room_i   (res_room),
    .res_push_o   (res_push),
    .res_o        (res_w)
  );

  lzwe_fifo #(.W($bits(lzwe_pkg::res_t)), .DEPTH(4)) u_res_q (
    .clk_i, .rst_ni,
    .push_i  (res_push),
    .wdata_i (res_w),
    .pop_i   (pop_i),
    .rdata_o (res_head),
    .full_o  (res_full),
    .empty_o (empty_o),
    .room2_o (res_room)
  );

  assign out_code_o   = res_head.out_code;
  assign final_code_o = res_head.final_code && !res_full | res_head.final_code;

endmodule

>>> rtl/lzwe_fifo.sv
// small register queue used in front of and behind the encoder engine
module lzwe_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         full_o,
  output logic         empty_o,
  output logic         room2_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign room2_o = (cnt_q <= CW'(DEPTH - 2));
  assign rdata_o = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (do_pop) begin
      rp_d = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/lzwe_engine.sv
// lzw engine: hashed dictionary with linear probing and epoch tags
module lzwe_engine #(
  parameter int unsigned DICT_ENTRIES = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  lzwe_pkg::item_t item_i,
  output logic            item_pop_o,
  input  logic            res_room_i,
  output logic            res_push_o,
  output lzwe_pkg::res_t  res_o
);
  localparam int unsigned CodeLimit = (DICT_ENTRIES < lzwe_pkg::MaxCodes) ?
                                      DICT_ENTRIES : lzwe_pkg::MaxCodes;
  localparam int unsigned HashAw = $clog2(CodeLimit) + 1;
  localparam int unsigned HashDepth = 1 << HashAw;
  localparam int unsigned EntW = lzwe_pkg::EpochW + lzwe_pkg::KeyW + lzwe_pkg::CodeW;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_LAST  = 3'd4;

  typedef struct packed {
    logic [lzwe_pkg::EpochW-1:0] tag;
    logic [lzwe_pkg::KeyW-1:0]   key;
    logic [lzwe_pkg::CodeW-1:0]  code;
  } entry_t;

  logic [2:0]                  state_q, state_d;
  logic [lzwe_pkg::CodeW-1:0]  prefix_q, prefix_d;
  logic                        pvalid_q, pvalid_d;
  logic [lzwe_pkg::NextW-1:0]  next_q, next_d;
  logic [lzwe_pkg::EpochW-1:0] epoch_q, epoch_d;
  logic [7:0]                  byte_q, byte_d;
  logic                        last_q, last_d;
  logic [HashAw-1:0]           addr_q, addr_d;

  entry_t            mem [HashDepth];
  logic [EntW-1:0]   rdata_q;
  entry_t            rd_ent;
  logic              we;
  entry_t            wdata;
  logic [lzwe_pkg::KeyW-1:0] key;
  logic [31:0]       mix;

  assign rd_ent = entry_t'(rdata_q);
  assign key    = {prefix_q, byte_q};
  // multiplicative hash of the prefix and new byte
  assign mix    = 32'({prefix_q, item_i.data_byte}) * 32'h9E3779B1;

  always_comb begin
    state_d    = state_q;
    prefix_d   = prefix_q;
    pvalid_d   = pvalid_q;
    next_d     = next_q;
    epoch_d    = epoch_q;
    byte_d     = byte_q;
    last_d     = last_q;
    addr_d     = addr_q;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{out_code: prefix_q, final_code: 1'b0};
    we         = 1'b0;
    wdata      = '{tag: epoch_q, key: key, code: next_q[lzwe_pkg::CodeW-1:0]};
    unique case (state_q)
      ST_CLEAR: begin
        we     = 1'b1;
        wdata  = '0;
        addr_d = addr_q + 1'b1;
        if (addr_q == {HashAw{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid_i && res_room_i) begin
          item_pop_o = 1'b1;
          byte_d     = item_i.data_byte;
          last_d     = item_i.final_byte;
          if (!pvalid_q) begin
            prefix_d = lzwe_pkg::CodeW'(item_i.data_byte);
            pvalid_d = 1'b1;
            state_d  = item_i.final_byte ? ST_LAST : ST_IDLE;
          end else begin
            addr_d  = mix[31 -: HashAw];
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (rd_ent.tag == epoch_q && rd_ent.key == key) begin
          prefix_d = rd_ent.code;
          state_d  = last_q ? ST_LAST : ST_IDLE;
        end else if (rd_ent.tag != epoch_q) begin
          // empty slot ends the probe: pair is absent
          res_push_o = 1'b1;
          if (next_q < lzwe_pkg::NextW'(CodeLimit)) begin
            we     = 1'b1;
            next_d = next_q + 1'b1;
          end
          prefix_d = lzwe_pkg::CodeW'(byte_q);
          state_d  = last_q ? ST_LAST : ST_IDLE;
        end else begin
          addr_d  = addr_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_LAST: begin
        res_push_o = 1'b1;
        res_o      = '{out_code: prefix_q, final_code: 1'b1};
        prefix_d   = '0;
        pvalid_d   = 1'b0;
        next_d     = lzwe_pkg::NextW'(lzwe_pkg::ByteCodes);
        // new epoch retires the old entries; on wrap the table is swept
        if (epoch_q == {lzwe_pkg::EpochW{1'b1}}) begin
          epoch_d = lzwe_pkg::EpochW'(1);
          addr_d  = '0;
          state_d = ST_CLEAR;
        end else begin
          epoch_d = epoch_q + 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      prefix_q <= '0;
      pvalid_q <= 1'b0;
      next_q   <= lzwe_pkg::NextW'(lzwe_pkg::ByteCodes);
      epoch_q  <= lzwe_pkg::EpochW'(1);
      addr_q   <= '0;
      byte_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      prefix_q <= prefix_d;
      pvalid_q <= pvalid_d;
      next_q   <= next_d;
      epoch_q  <= epoch_d;
      addr_q   <= addr_d;
      byte_q   <= byte_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr_q] <= wdata;
    end
    rdata_q <= mem[addr_q];
  end

endmodule

>>> bench/tb_lzw_byte_encoder.sv
// testbench of the lzw byte encoder: scoreboard of codes against a software dictionary
module tb_lzw_byte_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  // a small dictionary so that it fills within a short run
  localparam int unsigned DictEntries = 512;
  localparam int unsigned CodeLimit   = (DictEntries < lzwe_pkg::MaxCodes) ?
                                        DictEntries : lzwe_pkg::MaxCodes;
  localparam int unsigned MaxCycles   = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        push_i;
  logic        full_o;
  logic [7:0]  data_byte_i;
  logic        final_byte_i;
  logic        empty_o;
  logic        pop_i;
  logic [11:0] out_code_o;
  logic        final_code_o;

  lzw_byte_encoder #(.DICT_ENTRIES(DictEntries)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push_i), .full_o(full_o),
    .data_byte_i(data_byte_i), .final_byte_i(final_byte_i),
    .empty_o(empty_o), .pop_i(pop_i), .out_code_o(out_code_o),
    .final_code_o(final_code_o)
  );

  // software copy of the dictionary
  logic [lzwe_pkg::KeyW-1:0]  pair_table [lzwe_pkg::ByteCodes:CodeLimit-1];
  logic [lzwe_pkg::NextW-1:0] free_code;
  logic [lzwe_pkg::CodeW-1:0] cur_prefix;
  logic                       have_prefix;

  lzwe_pkg::res_t expected_codes [$];
  int   mismatches;
  int   cycle_count;
  int   hold_cycles;
  bit   heavy_stall;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void clear_dict();
    free_code   = lzwe_pkg::NextW'(lzwe_pkg::ByteCodes);
    cur_prefix  = '0;
    have_prefix = 1'b0;
  endfunction

  function automatic void predict_codes(logic [7:0] b, logic last);
    logic [lzwe_pkg::KeyW-1:0] key;
    int hit;
    lzwe_pkg::res_t r;
    if (!have_prefix) begin
      cur_prefix  = lzwe_pkg::CodeW'(b);
      have_prefix = 1'b1;
    end else begin
      key = {cur_prefix, b};
      hit = -1;
      for (int c = lzwe_pkg::ByteCodes; c < free_code; c++) begin
        if (pair_table[c] == key) begin
          hit = c;
          break;
        end
      end
      if (hit >= 0) begin
        cur_prefix = lzwe_pkg::CodeW'(hit);
      end else begin
        r.out_code = cur_prefix;
        r.final_code = 1'b0;
        expected_codes.push_back(r);
        if (free_code < CodeLimit) begin
          pair_table[free_code] = key;
          free_code++;
        end
        cur_prefix = lzwe_pkg::CodeW'(b);
      end
    end
    if (last) begin
      r.out_code = cur_prefix;
      r.final_code = 1'b1;
      expected_codes.push_back(r);
      clear_dict();
    end
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // sends one word and waits for it to be taken; push stays high between
  // back-to-back words
  task automatic send_byte(logic [7:0] b, logic last, bit gaps = 1);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      push_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push_i       <= 1'b1;
    data_byte_i  <= b;
    final_byte_i <= last;
    do @(posedge clk_i); while (full_o);
    predict_codes(b, last);
  endtask

  // receiver: random gaps between pops, with a long hold-off on request
  initial begin
    int g;
    pop_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (heavy_stall) begin
        pop_i <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 400) begin
          @(posedge clk_i);
          hold_cycles++;
        end
        heavy_stall = 1'b0;
      end
      g = pick_gap();
      if (g == 0) begin
        pop_i <= 1'b1;
      end else begin
        pop_i <= 1'b0;
        repeat (g) @(posedge clk_i);
        pop_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    lzwe_pkg::res_t exp_r;
    if (rst_ni && pop_i && !empty_o) begin
      if (expected_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: code %0d last %0b", out_code_o, final_code_o);
      end else begin
        exp_r = expected_codes.pop_front();
        if (out_code_o !== exp_r.out_code || final_code_o !== exp_r.final_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected code %0d last %0b, got code %0d last %0b",
                     exp_r.out_code, exp_r.final_code, out_code_o, final_code_o);
        end
      end
    end
  end

  task automatic send_message(int len, int alpha, bit gaps = 1);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, alpha - 1) + (alpha < 256 ? 8'h41 : 0)),
                i == len - 1, gaps);
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // repeated bytes build long chains
    for (int i = 0; i < 12; i++) send_byte(8'hAA, i == 11);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b1);
  endtask

  task automatic test_random_messages();
    for (int m = 0; m < 4; m++)
      send_message($urandom_range(1, 12), ($urandom_range(0, 3) == 0) ? 256 : 3);
  endtask

  task automatic test_backpressure();
    heavy_stall = 1'b1;
    send_message(30, 256, 0);
  endtask

  // fills the dictionary: random bytes over a long message with no gaps, then a short two-letter message with gaps
  task automatic test_full_dictionary();
    send_message(300, 256, 0);
    send_message(20, 2);
  endtask

  initial begin
    rst_ni = 1'b0;
    push_i = 1'b0;
    data_byte_i = '0;
    final_byte_i = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    heavy_stall = 1'b0;
    clear_dict();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_messages();
    test_backpressure();
    test_random_messages();
    test_full_dictionary();
    test_random_messages();
    push_i <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_codes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
